// File: design/rsch_pkg.sv
package rsch_pkg;

    // default field format
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // smallest accepted hit distance after reset, in fraction lsbs
    localparam int T_LOWER_RST = 66;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_T_LOWER = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_T_UPPER = 1'b1;

    // handshake between the sequencer and one serial arithmetic unit
    typedef struct packed {
        logic start;
    } rsch_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } rsch_rsp_t;

endpackage

// File: design/rsch_mul.sv
module rsch_mul
    import rsch_pkg::*;
#(
    parameter int XW = 68
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rsch_req_t              req,
    input  logic signed [XW-1:0]   op_a,
    input  logic signed [XW-1:0]   op_b,
    output rsch_rsp_t              rsp,
    output logic signed [2*XW-1:0] prod
);

    localparam int PW = 2 * XW;

    logic          busy_reg;
    logic          done_reg;
    logic [PW-1:0] ma_reg;
    logic [XW-1:0] mb_reg;
    logic [PW-1:0] acc_reg;
    logic          neg_reg;
    logic signed [PW-1:0] prod_reg;

    logic [XW-1:0] a_mag;
    logic [XW-1:0] b_mag;

    // operand magnitudes, sign handled at the end
    assign a_mag = op_a[XW-1] ? (~op_a + 1'b1) : op_a;
    assign b_mag = op_b[XW-1] ? (~op_b + 1'b1) : op_b;

    // control: runs while multiplier bits remain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && (mb_reg == '0))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // shift-add datapath, one multiplier bit per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            ma_reg  <= PW'(a_mag);
            mb_reg  <= b_mag;
            acc_reg <= '0;
            neg_reg <= op_a[XW-1] ^ op_b[XW-1];
        end
        else if (busy_reg)
        begin
            if (mb_reg == '0)
            begin
                prod_reg <= neg_reg ? $signed(~acc_reg + 1'b1) : $signed(acc_reg);
            end
            else
            begin
                if (mb_reg[0])
                begin
                    acc_reg <= acc_reg + ma_reg;
                end
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign prod     = prod_reg;

endmodule

// File: design/rsch_div.sv
module rsch_div
    import rsch_pkg::*;
#(
    parameter int NW    = 84,
    parameter int DEN_W = 65
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  rsch_req_t               req,
    input  logic signed [NW-1:0]    num,
    input  logic signed [DEN_W-1:0] den,
    output rsch_rsp_t               rsp,
    output logic signed [NW-1:0]    quot
);

    localparam int CW = $clog2(NW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NW-1:0]    un_reg;
    logic [DEN_W-1:0] ud_reg;
    logic [DEN_W-1:0] rem_reg;
    logic             neg_reg;
    logic signed [NW-1:0] quot_reg;

    logic [NW-1:0]    n_mag;
    logic [DEN_W-1:0] d_mag;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_dif;
    logic             take;

    assign n_mag = num[NW-1] ? (~num + 1'b1) : num;
    assign d_mag = den[DEN_W-1] ? (~den + 1'b1) : den;

    // one restoring step: bring down the next dividend bit
    assign rem_sh  = {rem_reg, un_reg[NW-1]};
    assign rem_dif = rem_sh - {1'b0, ud_reg};
    assign take    = (rem_sh >= {1'b0, ud_reg});

    // control: fixed count of quotient bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // quotient bits shift in behind the dividend bits
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            un_reg  <= n_mag;
            ud_reg  <= d_mag;
            rem_reg <= '0;
            neg_reg <= num[NW-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                // floor rounding for quotients of opposite sign
                if (!neg_reg)
                begin
                    quot_reg <= $signed(un_reg);
                end
                else if (rem_reg != '0)
                begin
                    quot_reg <= $signed(~un_reg);
                end
                else
                begin
                    quot_reg <= $signed(~un_reg + 1'b1);
                end
            end
            else
            begin
                rem_reg <= take ? rem_dif[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                un_reg  <= {un_reg[NW-2:0], take};
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign quot     = quot_reg;

endmodule

// File: design/rsch_sqrt.sv
module rsch_sqrt
    import rsch_pkg::*;
#(
    parameter int RW = 82
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  rsch_req_t       req,
    input  logic [2*RW-1:0] rad,
    output rsch_rsp_t       rsp,
    output logic [RW-1:0]   root
);

    localparam int CW = $clog2(RW + 1);

    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [2*RW-1:0] rad_reg;
    logic [RW+1:0]   rem_reg;
    logic [RW-1:0]   root_reg;

    logic [RW+3:0] rem_sh;
    logic [RW+3:0] trial;
    logic [RW+3:0] rem_dif;
    logic          take;

    // one root bit per step from the next two radicand bits
    assign rem_sh  = {rem_reg, rad_reg[2*RW-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign rem_dif = rem_sh - trial;
    assign take    = (rem_sh >= trial);

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(RW);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // digit recurrence
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            rem_reg  <= take ? rem_dif[RW+1:0] : rem_sh[RW+1:0];
            root_reg <= {root_reg[RW-2:0], take};
            rad_reg  <= rad_reg << 2;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign root     = root_reg;

endmodule

// File: design/ray_sphere_closest_hit_core.sv
// Closest hit of one ray against a run of spheres. Each input word carries the ray and
// one sphere in signed fixed point; the word with s_tlast set closes the run and yields
// one result word with the nearest accepted hit (distance, point, unit normal facing the
// ray, front-face flag), or hit = 0 and zeros when nothing lay between t_lower and
// t_upper. Spheres are handled one at a time by a sequencer over three bit-serial units:
// a shift-add multiplier (one multiplier bit per cycle, stops when the bits run out), a
// restoring divider and a square root. A new word is taken only when the previous sphere
// is finished; a finished result waits in an output register while the next run goes
// on. t_lower and t_upper are written through the cfg port; the user must write them
// only between words, as the core itself does not enforce it.
module ray_sphere_closest_hit_core
    import rsch_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    // origin_x, origin_y, origin_z, direction_x, direction_y, direction_z,
    // center_x, center_y, center_z, radius
    input  logic [((10*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                                s_tlast,   // last_sphere
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // hit_t, point_x, point_y, point_z, normal_x, normal_y, normal_z
    output logic [((7*COORD_WIDTH+6)/8)*8-1:0]  m_tdata,
    output logic [1:0]                          m_tuser,   // hit, front_face
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_wen,
    input  logic [CFG_INDEX_W-1:0]              cfg_index,
    input  logic [COORD_WIDTH-2:0]              cfg_data
);

    localparam int W        = COORD_WIDTH;
    localparam int F        = FRAC_BITS;
    localparam int TW       = W - 1;
    localparam int XW       = (2*W + 4 > W + F + 4) ? 2*W + 4 : W + F + 4;
    localparam int PW       = 2 * XW;
    localparam int RW       = 2*W + F + 2;
    localparam int NW       = 2*W + F + 4;
    localparam int DEN_W    = 2*W + 1;
    localparam int RAD_KEEP = 2*RW - 2*F;
    localparam int OUT_DW   = ((7*W + 6) / 8) * 8;

    localparam logic [1:0] AXIS_LAST = 2'd2;

    localparam logic signed [XW-1:0] SAT_HI = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [XW-1:0] SAT_LO = {{(XW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef enum logic [4:0] {
        S_IDLE,
        S_PRE_GO,
        S_PRE_WAIT,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_NEAR_GO,
        S_NEAR_WAIT,
        S_FAR_GO,
        S_FAR_WAIT,
        S_PT_GO,
        S_PT_WAIT,
        S_NRM_GO,
        S_NRM_WAIT,
        S_DOT_GO,
        S_DOT_WAIT,
        S_FIN
    } state_t;

    // products of the quadratic setup, in issue order
    typedef enum logic [3:0] {
        OP_DXX, OP_DYY, OP_DZZ,
        OP_HX,  OP_HY,  OP_HZ,
        OP_CX,  OP_CY,  OP_CZ,
        OP_RR,  OP_HH,  OP_AC
    } pre_op_t;

    state_t  state_reg, state_next;
    pre_op_t step_reg;
    logic [1:0] axis_reg;

    logic [TW-1:0] t_lower_reg;
    logic [TW-1:0] t_upper_reg;

    // captured word
    logic signed [W-1:0]  o_reg [3];
    logic signed [W-1:0]  d_reg [3];
    logic signed [W-1:0]  c_reg [3];
    logic signed [XW-1:0] oc_reg [3];
    logic signed [W-1:0]  r_reg;
    logic                 last_reg;

    // working values
    logic signed [PW-1:0] acc_reg;
    logic signed [XW-1:0] a_reg;
    logic signed [XW-1:0] h_reg;
    logic signed [XW-1:0] cc_reg;
    logic signed [PW-1:0] disc_reg;
    logic [RW-1:0]        s_reg;
    logic signed [NW-1:0] t_reg;
    logic signed [XW-1:0] p_reg [3];
    logic signed [XW-1:0] n_reg [3];

    // kept record of the current ray
    logic                 found_reg;
    logic                 best_front_reg;
    logic [TW-1:0]        best_t_reg;
    logic signed [W-1:0]  best_point_reg [3];
    logic signed [W-1:0]  best_normal_reg [3];

    // output word
    logic                 m_tvalid_reg;
    logic                 out_hit_reg;
    logic                 out_front_reg;
    logic [TW-1:0]        out_t_reg;
    logic signed [W-1:0]  out_point_reg [3];
    logic signed [W-1:0]  out_normal_reg [3];

    // unit connections
    rsch_req_t            mul_req, div_req, sqrt_req;
    rsch_rsp_t            mul_rsp, div_rsp, sqrt_rsp;
    logic signed [XW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_prod;
    logic signed [NW-1:0] div_num;
    logic signed [DEN_W-1:0] div_den;
    logic signed [NW-1:0] div_quot;
    logic [2*RW-1:0]      sqrt_rad;
    logic [RW-1:0]        sqrt_root;

    logic                 in_acc;
    logic                 out_free;
    logic                 emit;
    logic                 pre_first, pre_sub;
    logic signed [PW-1:0] acc_next;
    logic                 sphere_miss;
    logic signed [NW-1:0] hf;
    logic signed [NW-1:0] s_ext;
    logic [TW-1:0]        t_hi;
    logic                 t_ok;
    logic                 keep;
    logic                 front_next;

    function automatic logic signed [W-1:0] sat_w(input logic signed [XW-1:0] v);
        logic signed [W-1:0] res;
        if (v > SAT_HI)
        begin
            res = SAT_HI[W-1:0];
        end
        else if (v < SAT_LO)
        begin
            res = SAT_LO[W-1:0];
        end
        else
        begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign emit     = (state_reg == S_FIN) && last_reg && out_free;

    // serial units
    rsch_mul #(.XW(XW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .op_a  (mul_a),
        .op_b  (mul_b),
        .rsp   (mul_rsp),
        .prod  (mul_prod)
    );

    rsch_div #(.NW(NW), .DEN_W(DEN_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (div_den),
        .rsp   (div_rsp),
        .quot  (div_quot)
    );

    rsch_sqrt #(.RW(RW)) u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sqrt_req),
        .rad   (sqrt_rad),
        .rsp   (sqrt_rsp),
        .root  (sqrt_root)
    );

    assign mul_req.start  = (state_reg == S_PRE_GO) || (state_reg == S_PT_GO)
                          || (state_reg == S_DOT_GO);
    assign div_req.start  = (state_reg == S_NEAR_GO) || (state_reg == S_FAR_GO)
                          || (state_reg == S_NRM_GO);
    assign sqrt_req.start = (state_reg == S_SQRT_GO);

    // multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_PRE_GO:
            begin
                case (step_reg)
                    OP_DXX: begin mul_a = XW'(d_reg[0]); mul_b = XW'(d_reg[0]); end
                    OP_DYY: begin mul_a = XW'(d_reg[1]); mul_b = XW'(d_reg[1]); end
                    OP_DZZ: begin mul_a = XW'(d_reg[2]); mul_b = XW'(d_reg[2]); end
                    OP_HX:  begin mul_a = oc_reg[0];     mul_b = XW'(d_reg[0]); end
                    OP_HY:  begin mul_a = oc_reg[1];     mul_b = XW'(d_reg[1]); end
                    OP_HZ:  begin mul_a = oc_reg[2];     mul_b = XW'(d_reg[2]); end
                    OP_CX:  begin mul_a = oc_reg[0];     mul_b = oc_reg[0];     end
                    OP_CY:  begin mul_a = oc_reg[1];     mul_b = oc_reg[1];     end
                    OP_CZ:  begin mul_a = oc_reg[2];     mul_b = oc_reg[2];     end
                    OP_RR:  begin mul_a = XW'(r_reg);    mul_b = XW'(r_reg);    end
                    OP_HH:  begin mul_a = h_reg;         mul_b = h_reg;         end
                    OP_AC:  begin mul_a = cc_reg;        mul_b = a_reg;         end
                    default: ;
                endcase
            end
            S_PT_GO:
            begin
                mul_a = $signed(XW'(t_reg[TW-1:0]));
                mul_b = XW'(d_reg[axis_reg]);
            end
            S_DOT_GO:
            begin
                mul_a = n_reg[axis_reg];
                mul_b = XW'(d_reg[axis_reg]);
            end
            default: ;
        endcase
    end

    // sums of products: a, h, c, discriminant, dot(d, n)
    always_comb
    begin
        pre_first = (step_reg == OP_DXX) || (step_reg == OP_HX)
                 || (step_reg == OP_CX)  || (step_reg == OP_HH);
        pre_sub   = (step_reg == OP_RR)  || (step_reg == OP_AC);
        if (state_reg == S_DOT_WAIT)
        begin
            acc_next = ((axis_reg == '0) ? '0 : acc_reg) + mul_prod;
        end
        else
        begin
            acc_next = (pre_first ? '0 : acc_reg) + (pre_sub ? -mul_prod : mul_prod);
        end
    end

    assign sphere_miss = (r_reg == '0) || (a_reg == '0) || acc_next[PW-1];
    assign front_next  = acc_next[PW-1];

    // root operands and range test
    assign sqrt_rad = {disc_reg[RAD_KEEP-1:0], {(2*F){1'b0}}};
    assign hf       = -(NW'(h_reg) <<< F);
    assign s_ext    = $signed(NW'(s_reg));
    assign t_hi     = found_reg ? best_t_reg : t_upper_reg;
    assign t_ok     = !div_quot[NW-1] && ($unsigned(div_quot) >= NW'(t_lower_reg))
                   && ($unsigned(div_quot) <= NW'(t_hi));
    assign keep     = (state_reg == S_DOT_WAIT) && mul_rsp.done && (axis_reg == AXIS_LAST);

    always_comb
    begin
        div_num = '0;
        div_den = DEN_W'(a_reg);
        case (state_reg)
            S_NEAR_GO: div_num = hf - s_ext;
            S_FAR_GO:  div_num = hf + s_ext;
            S_NRM_GO:
            begin
                div_num = NW'(p_reg[axis_reg] - XW'(c_reg[axis_reg])) <<< F;
                div_den = DEN_W'(r_reg);
            end
            default: ;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (s_tvalid) state_next = S_PRE_GO;
            S_PRE_GO:    state_next = S_PRE_WAIT;
            S_PRE_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    if (step_reg != OP_AC)
                    begin
                        state_next = S_PRE_GO;
                    end
                    else
                    begin
                        state_next = sphere_miss ? S_FIN : S_SQRT_GO;
                    end
                end
            end
            S_SQRT_GO:   state_next = S_SQRT_WAIT;
            S_SQRT_WAIT: if (sqrt_rsp.done) state_next = S_NEAR_GO;
            S_NEAR_GO:   state_next = S_NEAR_WAIT;
            S_NEAR_WAIT: if (div_rsp.done) state_next = t_ok ? S_PT_GO : S_FAR_GO;
            S_FAR_GO:    state_next = S_FAR_WAIT;
            S_FAR_WAIT:  if (div_rsp.done) state_next = t_ok ? S_PT_GO : S_FIN;
            S_PT_GO:     state_next = S_PT_WAIT;
            S_PT_WAIT:   if (mul_rsp.done) state_next = S_NRM_GO;
            S_NRM_GO:    state_next = S_NRM_WAIT;
            S_NRM_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = (axis_reg == AXIS_LAST) ? S_DOT_GO : S_PT_GO;
                end
            end
            S_DOT_GO:    state_next = S_DOT_WAIT;
            S_DOT_WAIT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = (axis_reg == AXIS_LAST) ? S_FIN : S_DOT_GO;
                end
            end
            S_FIN:       if (!last_reg || out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // state, configuration and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            step_reg       <= OP_DXX;
            axis_reg       <= '0;
            t_lower_reg    <= TW'(T_LOWER_RST);
            t_upper_reg    <= '1;
            found_reg      <= 1'b0;
            best_front_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            out_hit_reg    <= 1'b0;
            out_front_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_T_LOWER: t_lower_reg <= cfg_data;
                    CFG_T_UPPER: t_upper_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (in_acc)
            begin
                step_reg <= OP_DXX;
                axis_reg <= '0;
            end
            else if ((state_reg == S_PRE_WAIT) && mul_rsp.done && (step_reg != OP_AC))
            begin
                step_reg <= pre_op_t'(step_reg + 4'd1);
            end
            else if ((state_reg == S_NRM_WAIT && div_rsp.done)
                  || (state_reg == S_DOT_WAIT && mul_rsp.done))
            begin
                axis_reg <= (axis_reg == AXIS_LAST) ? '0 : axis_reg + 2'd1;
            end

            if (keep)
            begin
                found_reg      <= 1'b1;
                best_front_reg <= front_next;
            end
            else if (emit)
            begin
                found_reg      <= 1'b0;
                best_front_reg <= 1'b0;
            end

            if (emit)
            begin
                m_tvalid_reg  <= 1'b1;
                out_hit_reg   <= found_reg;
                out_front_reg <= found_reg && best_front_reg;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o_reg[i]  <= s_tdata[i*W +: W];
                d_reg[i]  <= s_tdata[(3+i)*W +: W];
                c_reg[i]  <= s_tdata[(6+i)*W +: W];
                oc_reg[i] <= XW'($signed(s_tdata[i*W +: W]))
                           - XW'($signed(s_tdata[(6+i)*W +: W]));
            end
            r_reg    <= s_tdata[9*W +: W];
            last_reg <= s_tlast;
        end

        if ((state_reg == S_PRE_WAIT || state_reg == S_DOT_WAIT) && mul_rsp.done)
        begin
            acc_reg <= acc_next;
        end

        if ((state_reg == S_PRE_WAIT) && mul_rsp.done)
        begin
            case (step_reg)
                OP_DZZ:  a_reg    <= acc_next[XW-1:0];
                OP_HZ:   h_reg    <= acc_next[XW-1:0];
                OP_RR:   cc_reg   <= acc_next[XW-1:0];
                OP_AC:   disc_reg <= acc_next;
                default: ;
            endcase
        end

        if ((state_reg == S_SQRT_WAIT) && sqrt_rsp.done)
        begin
            s_reg <= sqrt_root;
        end

        if ((state_reg == S_NEAR_WAIT || state_reg == S_FAR_WAIT) && div_rsp.done)
        begin
            t_reg <= div_quot;
        end

        // hit point: origin plus floor(t * d) at the fixed point scale
        if ((state_reg == S_PT_WAIT) && mul_rsp.done)
        begin
            p_reg[axis_reg] <= XW'(o_reg[axis_reg]) + XW'(mul_prod >>> F);
        end

        if ((state_reg == S_NRM_WAIT) && div_rsp.done)
        begin
            n_reg[axis_reg] <= XW'(div_quot);
        end

        // new closest record, normal turned to face the ray
        if (keep)
        begin
            best_t_reg <= t_reg[TW-1:0];
            for (int i = 0; i < 3; i++)
            begin
                best_point_reg[i]  <= sat_w(p_reg[i]);
                best_normal_reg[i] <= sat_w(front_next ? n_reg[i] : -n_reg[i]);
            end
        end

        if (emit)
        begin
            out_t_reg <= found_reg ? best_t_reg : '0;
            for (int i = 0; i < 3; i++)
            begin
                out_point_reg[i]  <= found_reg ? best_point_reg[i] : '0;
                out_normal_reg[i] <= found_reg ? best_normal_reg[i] : '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = {out_front_reg, out_hit_reg};
    assign m_tdata  = OUT_DW'({out_normal_reg[2], out_normal_reg[1], out_normal_reg[0],
                               out_point_reg[2], out_point_reg[1], out_point_reg[0],
                               out_t_reg});

    // a unit only reports completion while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_PRE_WAIT || state_reg == S_PT_WAIT
                          || state_reg == S_DOT_WAIT))
        else $error("multiplier finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_NEAR_WAIT || state_reg == S_FAR_WAIT
                          || state_reg == S_NRM_WAIT))
        else $error("divider finished outside a wait state");

    assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_rsp.done |-> (state_reg == S_SQRT_WAIT))
        else $error("square root finished outside its wait state");

    // a freshly kept distance lies inside the accepted window
    assert property (@(posedge clk) disable iff (!rst_n)
        keep |-> (t_reg[TW-1:0] <= t_hi) && (t_reg[TW-1:0] >= t_lower_reg))
        else $error("kept hit distance out of range");

endmodule
